// File: sv/sorted_key_table_search_core_defines.svh
// ----------------------------------------------------------------------------
// Sorted key table search: assertion macros
// Shared concurrent assertion forms for the sorted key table blocks.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define SKTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SKTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define SKTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/skts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table search package
// Commands, status codes, defaults and the control word that walks the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skts_pkg;

  localparam int CAPACITY_DFLT   = 256;
  localparam int WORD_WIDTH_DFLT = 32;
  localparam int CNT_WIDTH_DFLT  = $clog2(CAPACITY_DFLT + 1);
  localparam int CMD_WIDTH       = 3;
  localparam int STATUS_WIDTH    = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_INTERVAL = 3'd2,
    CMD_NEAREST  = 3'd3,
    CMD_RANGE    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STS_OK       = 2'd0,
    STS_REPLACED = 2'd1,
    STS_FULL     = 2'd2,
    STS_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t cmd;
    logic has_prev;
    logic placed;
    logic live;
    logic repl;
    logic full;
  } ctl_t;

endpackage

`default_nettype wire

// File: sv/skts_if.sv
// ----------------------------------------------------------------------------
// Sorted key table search channels
// Valid/ready transaction channels for commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skts_in_if #(
  parameter int WORD_WIDTH = skts_pkg::WORD_WIDTH_DFLT
);
  logic                                valid;
  logic                                ready;
  logic        [skts_pkg::CMD_WIDTH-1:0] cmd;
  logic signed [WORD_WIDTH-1:0]        key;
  logic signed [WORD_WIDTH-1:0]        sample_value;
  logic signed [WORD_WIDTH-1:0]        slope;

  modport source (output valid, cmd, key, sample_value, slope, input ready);
  modport sink   (input valid, cmd, key, sample_value, slope, output ready);
endinterface

interface skts_out_if #(
  parameter int WORD_WIDTH = skts_pkg::WORD_WIDTH_DFLT,
  parameter int CNT_WIDTH  = skts_pkg::CNT_WIDTH_DFLT
);
  logic                                   valid;
  logic                                   ready;
  logic        [CNT_WIDTH-1:0]            index;
  logic signed [WORD_WIDTH-1:0]           range_low;
  logic signed [WORD_WIDTH-1:0]           range_high;
  logic        [CNT_WIDTH-1:0]            entry_count;
  logic        [skts_pkg::STATUS_WIDTH-1:0] status;

  modport source (output valid, index, range_low, range_high, entry_count, status,
                  input ready);
  modport sink   (input valid, index, range_low, range_high, entry_count, status,
                  output ready);
endinterface

`default_nettype wire

// File: sv/skts_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one table entry; updates it from the passing transaction and hands
// the transaction on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skts_cell #(
  parameter int WORD_WIDTH = skts_pkg::WORD_WIDTH_DFLT,
  parameter int CNT_WIDTH  = skts_pkg::CNT_WIDTH_DFLT
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         vld_i,
  input  skts_pkg::ctl_t              ctl_i,
  input  wire signed [WORD_WIDTH-1:0] key_i,
  input  wire signed [WORD_WIDTH-1:0] val_i,
  input  wire signed [WORD_WIDTH-1:0] slope_i,
  input  wire signed [WORD_WIDTH-1:0] prev_i,
  input  wire        [CNT_WIDTH-1:0]  rem_i,
  input  wire        [CNT_WIDTH-1:0]  cnt_i,
  output logic                        vld_o,
  output skts_pkg::ctl_t              ctl_o,
  output logic signed [WORD_WIDTH-1:0] key_o,
  output logic signed [WORD_WIDTH-1:0] val_o,
  output logic signed [WORD_WIDTH-1:0] slope_o,
  output logic signed [WORD_WIDTH-1:0] prev_o,
  output logic        [CNT_WIDTH-1:0]  rem_o,
  output logic        [CNT_WIDTH-1:0]  cnt_o
);

  logic signed [WORD_WIDTH-1:0] ent_key_r, ent_key_nxt;
  logic signed [WORD_WIDTH-1:0] ent_val_r, ent_val_nxt;
  logic signed [WORD_WIDTH-1:0] ent_slope_r, ent_slope_nxt;

  logic                         vld_r;
  skts_pkg::ctl_t               ctl_r, ctl_nxt;
  logic signed [WORD_WIDTH-1:0] key_r, key_nxt;
  logic signed [WORD_WIDTH-1:0] val_r, val_nxt;
  logic signed [WORD_WIDTH-1:0] slope_r, slope_nxt;
  logic signed [WORD_WIDTH-1:0] prev_r, prev_nxt;
  logic        [CNT_WIDTH-1:0]  rem_r, rem_nxt;
  logic        [CNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  logic                         occ;
  logic                         key_le;
  logic                         key_eq;
  logic signed [WORD_WIDTH:0]   twice_q;
  logic signed [WORD_WIDTH:0]   pair_sum;
  logic                         mid_ge;

  always_comb begin
    occ      = (rem_i != '0);
    key_le   = (ent_key_r <= key_i);
    key_eq   = (ent_key_r == key_i);
    twice_q  = {key_i, 1'b0};
    pair_sum = {prev_i[WORD_WIDTH-1], prev_i} + {ent_key_r[WORD_WIDTH-1], ent_key_r};
    mid_ge   = (twice_q >= pair_sum);

    ent_key_nxt   = ent_key_r;
    ent_val_nxt   = ent_val_r;
    ent_slope_nxt = ent_slope_r;

    ctl_nxt          = ctl_i;
    ctl_nxt.has_prev = ctl_i.has_prev | occ;
    key_nxt          = key_i;
    val_nxt          = val_i;
    slope_nxt        = slope_i;
    prev_nxt         = occ ? ent_key_r : prev_i;
    rem_nxt          = occ ? rem_i - CNT_WIDTH'(1) : '0;
    cnt_nxt          = cnt_i;

    if (vld_i) begin
      unique case (ctl_i.cmd)
        skts_pkg::CMD_INSERT: begin
          if (!ctl_i.placed && !ctl_i.repl) begin
            if (occ && key_le) begin
              cnt_nxt = cnt_i + CNT_WIDTH'(1);
              if (key_eq) begin
                ent_val_nxt   = val_i;
                ent_slope_nxt = slope_i;
                ctl_nxt.repl  = 1'b1;
              end
            end else if (!ctl_i.full) begin
              ent_key_nxt    = key_i;
              ent_val_nxt    = val_i;
              ent_slope_nxt  = slope_i;
              key_nxt        = ent_key_r;
              val_nxt        = ent_val_r;
              slope_nxt      = ent_slope_r;
              ctl_nxt.placed = 1'b1;
              ctl_nxt.live   = occ;
            end
          end else if (ctl_i.placed && ctl_i.live) begin
            ent_key_nxt   = key_i;
            ent_val_nxt   = val_i;
            ent_slope_nxt = slope_i;
            key_nxt       = ent_key_r;
            val_nxt       = ent_val_r;
            slope_nxt     = ent_slope_r;
            ctl_nxt.live  = occ;
          end
        end
        skts_pkg::CMD_INTERVAL: begin
          if (occ && key_le) begin
            cnt_nxt = cnt_i + CNT_WIDTH'(1);
          end
        end
        skts_pkg::CMD_NEAREST: begin
          if (occ && ctl_i.has_prev && mid_ge) begin
            cnt_nxt = cnt_i + CNT_WIDTH'(1);
          end
        end
        skts_pkg::CMD_RANGE: begin
          if (occ && !ctl_i.has_prev) begin
            key_nxt = ent_key_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_key_r   <= ent_key_nxt;
    ent_val_r   <= ent_val_nxt;
    ent_slope_r <= ent_slope_nxt;
    ctl_r       <= ctl_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    slope_r     <= slope_nxt;
    prev_r      <= prev_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
  end

  assign vld_o   = vld_r;
  assign ctl_o   = ctl_r;
  assign key_o   = key_r;
  assign val_o   = val_r;
  assign slope_o = slope_r;
  assign prev_o  = prev_r;
  assign rem_o   = rem_r;
  assign cnt_o   = cnt_r;

endmodule

`default_nettype wire

// File: sv/skts_chain.sv
// ----------------------------------------------------------------------------
// Sorted key table cell chain
// Row of table cells; a transaction enters the first cell and passes through
// each cell's registers in turn before it leaves the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skts_chain #(
  parameter int CAPACITY   = skts_pkg::CAPACITY_DFLT,
  parameter int WORD_WIDTH = skts_pkg::WORD_WIDTH_DFLT,
  parameter int CNT_WIDTH  = $clog2(CAPACITY + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          vld_i,
  input  skts_pkg::ctl_t               ctl_i,
  input  wire signed [WORD_WIDTH-1:0]  key_i,
  input  wire signed [WORD_WIDTH-1:0]  val_i,
  input  wire signed [WORD_WIDTH-1:0]  slope_i,
  input  wire signed [WORD_WIDTH-1:0]  prev_i,
  input  wire        [CNT_WIDTH-1:0]   rem_i,
  input  wire        [CNT_WIDTH-1:0]   cnt_i,
  output logic                         vld_o,
  output skts_pkg::ctl_t               ctl_o,
  output logic signed [WORD_WIDTH-1:0] key_o,
  output logic signed [WORD_WIDTH-1:0] prev_o,
  output logic        [CNT_WIDTH-1:0]  cnt_o
);

  logic                         vld_w   [0:CAPACITY];
  skts_pkg::ctl_t               ctl_w   [0:CAPACITY];
  logic signed [WORD_WIDTH-1:0] key_w   [0:CAPACITY];
  logic signed [WORD_WIDTH-1:0] val_w   [0:CAPACITY];
  logic signed [WORD_WIDTH-1:0] slope_w [0:CAPACITY];
  logic signed [WORD_WIDTH-1:0] prev_w  [0:CAPACITY];
  logic        [CNT_WIDTH-1:0]  rem_w   [0:CAPACITY];
  logic        [CNT_WIDTH-1:0]  cnt_w   [0:CAPACITY];

  assign vld_w[0]   = vld_i;
  assign ctl_w[0]   = ctl_i;
  assign key_w[0]   = key_i;
  assign val_w[0]   = val_i;
  assign slope_w[0] = slope_i;
  assign prev_w[0]  = prev_i;
  assign rem_w[0]   = rem_i;
  assign cnt_w[0]   = cnt_i;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    skts_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_i   (vld_w[g]),
      .ctl_i   (ctl_w[g]),
      .key_i   (key_w[g]),
      .val_i   (val_w[g]),
      .slope_i (slope_w[g]),
      .prev_i  (prev_w[g]),
      .rem_i   (rem_w[g]),
      .cnt_i   (cnt_w[g]),
      .vld_o   (vld_w[g+1]),
      .ctl_o   (ctl_w[g+1]),
      .key_o   (key_w[g+1]),
      .val_o   (val_w[g+1]),
      .slope_o (slope_w[g+1]),
      .prev_o  (prev_w[g+1]),
      .rem_o   (rem_w[g+1]),
      .cnt_o   (cnt_w[g+1])
    );
  end

  assign vld_o  = vld_w[CAPACITY];
  assign ctl_o  = ctl_w[CAPACITY];
  assign key_o  = key_w[CAPACITY];
  assign prev_o = prev_w[CAPACITY];
  assign cnt_o  = cnt_w[CAPACITY];

endmodule

`default_nettype wire

// File: sv/sorted_key_table_search_core.sv
// ----------------------------------------------------------------------------
// Sorted key table search core
// Usage:
//   in_chan carries one command per transaction (insert, clear, interval
//   lookup, nearest lookup, key range) with a key and, for insert, a value
//   and a slope. out_chan returns exactly one result per command: index,
//   range_low, range_high, entry_count and status.
//   The table lives in a row of CAPACITY cells, one entry per cell. Each
//   command walks the row one cell per cycle; its result is registered in
//   a result stage at the end of the row.
//   One command is in flight at a time; in_chan.ready returns once the
//   result has moved into the output register, so a new command is not
//   taken before the last one's result has left the result stage.
//   A result waits in the output register while out_chan.ready is low; the
//   next command is still accepted and runs behind it, then holds in a
//   result stage until the output register frees.
//   Reset empties the table (entry count zero) and drops any command in
//   flight; no clearing pass is needed, and ready is high the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_search_core_defines.svh"

module sorted_key_table_search_core #(
  parameter int CAPACITY   = skts_pkg::CAPACITY_DFLT,
  parameter int WORD_WIDTH = skts_pkg::WORD_WIDTH_DFLT
) (
  input  wire         clk,
  input  wire         rst_n,
  skts_in_if.sink     in_chan,
  skts_out_if.source  out_chan
);

  localparam int CNT_WIDTH = $clog2(CAPACITY + 1);
  localparam logic [CNT_WIDTH-1:0] CAP_CNT = CNT_WIDTH'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_WIDTH-1:0]         fill_r, fill_nxt;

  logic                         in_acc;
  logic                         out_acc;

  logic                         inj_vld_r;
  skts_pkg::ctl_t               inj_ctl_r;
  logic signed [WORD_WIDTH-1:0] inj_key_r;
  logic signed [WORD_WIDTH-1:0] inj_val_r;
  logic signed [WORD_WIDTH-1:0] inj_slope_r;
  logic [CNT_WIDTH-1:0]         inj_rem_r;

  logic                         tail_vld;
  skts_pkg::ctl_t               tail_ctl;
  logic signed [WORD_WIDTH-1:0] tail_key;
  logic signed [WORD_WIDTH-1:0] tail_prev;
  logic [CNT_WIDTH-1:0]         tail_cnt;

  logic [CNT_WIDTH-1:0]         res_idx_nxt, res_idx_r;
  logic signed [WORD_WIDTH-1:0] res_lo_nxt, res_lo_r;
  logic signed [WORD_WIDTH-1:0] res_hi_nxt, res_hi_r;
  skts_pkg::status_t            res_sts_nxt, res_sts_r;

  logic                         out_vld_r;
  logic [CNT_WIDTH-1:0]         out_idx_r;
  logic signed [WORD_WIDTH-1:0] out_lo_r;
  logic signed [WORD_WIDTH-1:0] out_hi_r;
  logic [CNT_WIDTH-1:0]         out_cnt_r;
  skts_pkg::status_t            out_sts_r;
  logic                         res_move;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign out_acc       = out_vld_r & out_chan.ready;
  assign res_move      = (state_r == ST_HOLD) && (!out_vld_r || out_chan.ready);

  skts_chain #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH),
    .CNT_WIDTH  (CNT_WIDTH)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (inj_vld_r),
    .ctl_i   (inj_ctl_r),
    .key_i   (inj_key_r),
    .val_i   (inj_val_r),
    .slope_i (inj_slope_r),
    .prev_i  ('0),
    .rem_i   (inj_rem_r),
    .cnt_i   ('0),
    .vld_o   (tail_vld),
    .ctl_o   (tail_ctl),
    .key_o   (tail_key),
    .prev_o  (tail_prev),
    .cnt_o   (tail_cnt)
  );

  always_comb begin
    res_idx_nxt = '0;
    res_lo_nxt  = '0;
    res_hi_nxt  = '0;
    res_sts_nxt = skts_pkg::STS_OK;
    fill_nxt    = fill_r;
    unique case (tail_ctl.cmd)
      skts_pkg::CMD_INSERT: begin
        if (tail_ctl.repl) begin
          res_idx_nxt = tail_cnt - CNT_WIDTH'(1);
          res_sts_nxt = skts_pkg::STS_REPLACED;
        end else if (tail_ctl.full) begin
          res_idx_nxt = tail_cnt;
          res_sts_nxt = skts_pkg::STS_FULL;
        end else begin
          res_idx_nxt = tail_cnt;
          fill_nxt    = fill_r + CNT_WIDTH'(1);
        end
      end
      skts_pkg::CMD_CLEAR: begin
        fill_nxt = '0;
      end
      skts_pkg::CMD_INTERVAL: begin
        res_idx_nxt = tail_cnt;
      end
      skts_pkg::CMD_NEAREST: begin
        if (fill_r == '0) begin
          res_sts_nxt = skts_pkg::STS_EMPTY;
        end else begin
          res_idx_nxt = tail_cnt;
        end
      end
      skts_pkg::CMD_RANGE: begin
        if (fill_r == '0) begin
          res_sts_nxt = skts_pkg::STS_EMPTY;
        end else begin
          res_lo_nxt = tail_key;
          res_hi_nxt = tail_prev;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)   state_nxt = ST_RUN;
      ST_RUN:  if (tail_vld) state_nxt = ST_HOLD;
      ST_HOLD: if (res_move) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      inj_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      inj_vld_r <= in_acc;
      if (tail_vld) begin
        fill_r <= fill_nxt;
      end
      if (res_move) begin
        out_vld_r <= 1'b1;
      end else if (out_acc) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inj_ctl_r.cmd      <= skts_pkg::cmd_t'(in_chan.cmd);
      inj_ctl_r.has_prev <= 1'b0;
      inj_ctl_r.placed   <= 1'b0;
      inj_ctl_r.live     <= 1'b0;
      inj_ctl_r.repl     <= 1'b0;
      inj_ctl_r.full     <= (fill_r == CAP_CNT);
      inj_key_r          <= in_chan.key;
      inj_val_r          <= in_chan.sample_value;
      inj_slope_r        <= in_chan.slope;
      inj_rem_r          <= fill_r;
    end
    if (tail_vld) begin
      res_idx_r <= res_idx_nxt;
      res_lo_r  <= res_lo_nxt;
      res_hi_r  <= res_hi_nxt;
      res_sts_r <= res_sts_nxt;
    end
    if (res_move) begin
      out_idx_r <= res_idx_r;
      out_lo_r  <= res_lo_r;
      out_hi_r  <= res_hi_r;
      out_sts_r <= res_sts_r;
      out_cnt_r <= fill_r;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.index       = out_idx_r;
  assign out_chan.range_low   = out_lo_r;
  assign out_chan.range_high  = out_hi_r;
  assign out_chan.entry_count = out_cnt_r;
  assign out_chan.status      = out_sts_r;

  `SKTS_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= CAP_CNT, "count above capacity")
  `SKTS_ASSERT_IMPLY(a_tail_in_run, clk, rst_n, tail_vld, state_r == ST_RUN, "tail outside run")
  `SKTS_ASSERT_NEXT(a_inject, clk, rst_n, in_acc, inj_vld_r && state_r == ST_RUN, "not injected")
  `SKTS_ASSERT_NEXT(a_fill_hold, clk, rst_n, !tail_vld, $stable(fill_r), "count moved")

endmodule

`default_nettype wire
